[hw/rtl/lsa_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lsa_pkg: shared types and constants of the LCG skip-ahead element generator
// Widths, register indexes, sequencer states and the constant jump tables
// used by the shared-multiplier skip-ahead loop.
// ---------------------------------------------------------------------------
package lsa_pkg;

   // Dimension limits
   localparam int MAX_DIM  = 1048576;
   localparam int MAX_TILE = 256;

   localparam int DIM_BITS   = $clog2(MAX_DIM);        // tile index width
   localparam int DIM_W      = DIM_BITS + 1;           // dimension register width
   localparam int ELEM_W     = $clog2(MAX_TILE);       // element index width
   localparam int TILE_W     = ELEM_W + 1;             // tile size register width
   localparam int POS_W      = DIM_BITS + ELEM_W + 1;  // global row / column width
   localparam int SUM_BITS   = 2 * DIM_BITS + 1;       // row + col * total_rows
   localparam int JUMP_BITS  = SUM_BITS + 1;           // doubled in complex mode
   localparam int KW         = $clog2(JUMP_BITS);      // jump bit counter width
   localparam int Q_W        = 33;                     // Q.32 value width
   localparam int REAL_W     = 32 + DIM_W + 1;         // real value with bump
   localparam int MUL_W      = 32;                     // shared multiplier operand
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // LCG constants
   localparam logic [63:0]    LCG_MUL  = 64'd6364136223846793005;
   localparam logic [63:0]    LCG_ADD  = 64'd1;
   localparam logic [Q_W-1:0] HALF_Q32 = 33'h0_8000_0000;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED       = 3'd0,
      CSR_TOTAL_ROWS = 3'd1,
      CSR_TOTAL_COLS = 3'd2,
      CSR_LOCAL_ROWS = 3'd3,
      CSR_LOCAL_COLS = 3'd4,
      CSR_TILE_SIZE  = 3'd5,
      CSR_CHOLESKY   = 3'd6,
      CSR_COMPLEX    = 3'd7
   } lsa_csr_type;

   // Configuration after range clamping
   typedef struct packed {
      logic [63:0]       seed;
      logic [DIM_W-1:0]  total_rows;
      logic [DIM_W-1:0]  total_cols;
      logic [DIM_W-1:0]  local_rows;
      logic [DIM_W-1:0]  local_cols;
      logic [TILE_W-1:0] tile_size;
      logic              cholesky_mode;
      logic              complex_mode;
   } lsa_cfg_type;

   // Sequencer states
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ROW   = 8'b0000_0010,
      ST_COL   = 8'b0000_0100,
      ST_CHECK = 8'b0000_1000,
      ST_JUMP  = 8'b0001_0000,
      ST_LOAD  = 8'b0010_0000,
      ST_SKIP  = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } lsa_state_type;

   // Partial product phases of one 64-bit LCG step
   typedef enum logic [1:0] {
      PH_TEST = 2'd0,
      PH_LO   = 2'd1,
      PH_MID  = 2'd2,
      PH_HI   = 2'd3
   } lsa_phase_type;

   typedef logic [JUMP_BITS-1:0][63:0] lsa_tab_type;

   // Multiplier of a jump by 2^k steps: LCG_MUL^(2^k)
   function automatic lsa_tab_type lcg_mul_tab();
      lsa_tab_type tab;
      logic [63:0] a;
      a = LCG_MUL;
      for (int k = 0; k < JUMP_BITS; k++) begin
         tab[k] = a;
         a = a * a;
      end
      return tab;
   endfunction

   // Increment of a jump by 2^k steps
   function automatic lsa_tab_type lcg_add_tab();
      lsa_tab_type tab;
      logic [63:0] a;
      logic [63:0] c;
      a = LCG_MUL;
      c = LCG_ADD;
      for (int k = 0; k < JUMP_BITS; k++) begin
         tab[k] = c;
         c = c * (a + 64'd1);
         a = a * a;
      end
      return tab;
   endfunction

   localparam lsa_tab_type SKIP_MUL = lcg_mul_tab();
   localparam lsa_tab_type SKIP_ADD = lcg_add_tab();

   // 0.5 - s * 2^-64 in Q.32 from the upper half of the state
   function automatic logic signed [Q_W-1:0] to_q32(input logic [31:0] hi);
      return $signed(HALF_Q32 - {1'b0, hi});
   endfunction

endpackage
`default_nettype wire

[hw/rtl/lsa_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lsa_if: request and response channels of the element generator
// Valid/ready channels; a word moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface lsa_req_if;
   import lsa_pkg::*;

   logic              valid;
   logic              ready;
   logic [DIM_BITS-1:0] tile_row;
   logic [DIM_BITS-1:0] tile_col;
   logic [ELEM_W-1:0]   elem_row;
   logic [ELEM_W-1:0]   elem_col;

   modport source (output valid, tile_row, tile_col, elem_row, elem_col, input ready);
   modport sink   (input valid, tile_row, tile_col, elem_row, elem_col, output ready);
endinterface

interface lsa_rsp_if;
   import lsa_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [REAL_W-1:0] real_part;
   logic signed [Q_W-1:0]    imag_part;
   logic                     padding;

   modport source (output valid, real_part, imag_part, padding, input ready);
   modport sink   (input valid, real_part, imag_part, padding, output ready);
endinterface
`default_nettype wire

[hw/rtl/lsa_mul32.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lsa_mul32: shared 32x32 unsigned multiplier
// Full 64-bit product, registered; result in the cycle after the operands.
// ---------------------------------------------------------------------------
module lsa_mul32 (
   input  logic                          clock,
   input  logic [lsa_pkg::MUL_W-1:0]     op_a,
   input  logic [lsa_pkg::MUL_W-1:0]     op_b,
   output logic [2*lsa_pkg::MUL_W-1:0]   prod_ff
);
   import lsa_pkg::*;

   logic [2*MUL_W-1:0] prod_in;

   assign prod_in = (2*MUL_W)'(op_a) * (2*MUL_W)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

[hw/rtl/lsa_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lsa_core: sequencer and datapath of the element generator
// Forms global coordinates and the jump count, jumps the LCG ahead bit by
// bit on the shared multiplier, and holds the result word in an output
// register.
// ---------------------------------------------------------------------------
module lsa_core (
   input  logic                 clock,
   input  logic                 reset,
   input  lsa_pkg::lsa_cfg_type cfg,
   lsa_req_if.sink              req,
   lsa_rsp_if.source            rsp
);
   import lsa_pkg::*;

   lsa_state_type             state_ff, state_in;
   lsa_phase_type             ph_ff, ph_in;
   logic [KW-1:0]             k_ff, k_in;
   logic                      second_ff, second_in;
   logic [DIM_BITS-1:0]       tile_row_ff, tile_row_in;
   logic [DIM_BITS-1:0]       tile_col_ff, tile_col_in;
   logic [ELEM_W-1:0]         elem_row_ff, elem_row_in;
   logic [ELEM_W-1:0]         elem_col_ff, elem_col_in;
   logic [POS_W-1:0]          grow_ff, grow_in;
   logic [POS_W-1:0]          gcol_ff, gcol_in;
   logic                      pad_ff, pad_in;
   logic [JUMP_BITS-1:0]      jump_ff, jump_in;
   logic [63:0]               s_ff, s_in;
   logic [63:0]               acc_ff, acc_in;
   logic signed [Q_W-1:0]     re_ff, re_in;
   logic signed [Q_W-1:0]     im_ff, im_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [REAL_W-1:0]  rsp_real_ff, rsp_real_in;
   logic signed [Q_W-1:0]     rsp_imag_ff, rsp_imag_in;
   logic                      rsp_pad_ff, rsp_pad_in;

   logic [MUL_W-1:0]          mul_a;
   logic [MUL_W-1:0]          mul_b;
   logic [2*MUL_W-1:0]        mul_prod;
   logic [63:0]               tab_a;
   logic [63:0]               tab_c;
   logic [SUM_BITS-1:0]       jump_sum;
   logic [DIM_W-1:0]          dim_max;
   logic                      bump;
   logic signed [REAL_W-1:0]  re_wide;
   logic                      slot_free;

   lsa_mul32 u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_prod)
   );

   // Jump table entry for the current count bit
   assign tab_a = SKIP_MUL[k_ff];
   assign tab_c = SKIP_ADD[k_ff];

   assign jump_sum  = mul_prod[SUM_BITS-1:0] + SUM_BITS'(grow_ff);
   assign dim_max   = (cfg.total_rows > cfg.total_cols) ? cfg.total_rows : cfg.total_cols;
   assign bump      = cfg.cholesky_mode && (grow_ff == gcol_ff);
   assign re_wide   = REAL_W'(re_ff);
   assign slot_free = !rsp_valid_ff || rsp.ready;

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.real_part = rsp_real_ff;
   assign rsp.imag_part = rsp_imag_ff;
   assign rsp.padding   = rsp_pad_ff;

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      k_in         = k_ff;
      second_in    = second_ff;
      tile_row_in  = tile_row_ff;
      tile_col_in  = tile_col_ff;
      elem_row_in  = elem_row_ff;
      elem_col_in  = elem_col_ff;
      grow_in      = grow_ff;
      gcol_in      = gcol_ff;
      pad_in       = pad_ff;
      jump_in      = jump_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_real_in  = rsp_real_ff;
      rsp_imag_in  = rsp_imag_ff;
      rsp_pad_in   = rsp_pad_ff;
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               tile_row_in = req.tile_row;
               tile_col_in = req.tile_col;
               elem_row_in = req.elem_row;
               elem_col_in = req.elem_col;
               state_in    = ST_ROW;
            end
         end
         ST_ROW: begin
            mul_a    = MUL_W'(tile_row_ff);
            mul_b    = MUL_W'(cfg.tile_size);
            state_in = ST_COL;
         end
         ST_COL: begin
            grow_in  = mul_prod[POS_W-1:0] + POS_W'(elem_row_ff);
            mul_a    = MUL_W'(tile_col_ff);
            mul_b    = MUL_W'(cfg.tile_size);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // bounds check on the tile and on the local block
            gcol_in = mul_prod[POS_W-1:0] + POS_W'(elem_col_ff);
            pad_in  = (TILE_W'(elem_row_ff) >= cfg.tile_size) ||
                      (TILE_W'(elem_col_ff) >= cfg.tile_size) ||
                      (grow_ff >= POS_W'(cfg.local_rows)) ||
                      (gcol_in >= POS_W'(cfg.local_cols));
            state_in = pad_in ? ST_FIN : ST_JUMP;
         end
         ST_JUMP: begin
            mul_a    = MUL_W'(gcol_ff);
            mul_b    = MUL_W'(cfg.total_rows);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            jump_in   = cfg.complex_mode ? {jump_sum, 1'b0} : {1'b0, jump_sum};
            s_in      = cfg.seed;
            k_in      = '0;
            ph_in     = PH_TEST;
            second_in = 1'b0;
            state_in  = ST_SKIP;
         end
         ST_SKIP: begin
            case (ph_ff)
               PH_TEST: begin
                  if (jump_ff == '0) begin
                     // count exhausted: take the draw
                     if (second_ff) begin
                        im_in    = to_q32(s_ff[63:32]);
                        state_in = ST_FIN;
                     end else begin
                        re_in = to_q32(s_ff[63:32]);
                        im_in = '0;
                        if (cfg.complex_mode) begin
                           // one more plain LCG step for the imaginary part
                           jump_in   = JUMP_BITS'(1);
                           k_in      = '0;
                           second_in = 1'b1;
                        end else begin
                           state_in = ST_FIN;
                        end
                     end
                  end else if (!jump_ff[0]) begin
                     jump_in = jump_ff >> 1;
                     k_in    = k_ff + KW'(1);
                  end else begin
                     mul_a = tab_a[31:0];
                     mul_b = s_ff[31:0];
                     ph_in = PH_LO;
                  end
               end
               PH_LO: begin
                  acc_in = mul_prod + tab_c;
                  mul_a  = tab_a[31:0];
                  mul_b  = s_ff[63:32];
                  ph_in  = PH_MID;
               end
               PH_MID: begin
                  acc_in = acc_ff + {mul_prod[31:0], 32'd0};
                  mul_a  = tab_a[63:32];
                  mul_b  = s_ff[31:0];
                  ph_in  = PH_HI;
               end
               default: begin
                  s_in    = acc_ff + {mul_prod[31:0], 32'd0};
                  jump_in = jump_ff >> 1;
                  k_in    = k_ff + KW'(1);
                  ph_in   = PH_TEST;
               end
            endcase
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pad_in   = pad_ff;
               if (pad_ff) begin
                  rsp_real_in = '0;
                  rsp_imag_in = '0;
               end else if (bump) begin
                  rsp_real_in = re_wide + $signed({1'b0, dim_max, 32'd0});
                  rsp_imag_in = '0;
               end else begin
                  rsp_real_in = re_wide;
                  rsp_imag_in = im_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= PH_TEST;
         k_ff         <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         k_ff         <= k_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tile_row_ff <= tile_row_in;
      tile_col_ff <= tile_col_in;
      elem_row_ff <= elem_row_in;
      elem_col_ff <= elem_col_in;
      grow_ff     <= grow_in;
      gcol_ff     <= gcol_in;
      pad_ff      <= pad_in;
      jump_ff     <= jump_in;
      s_ff        <= s_in;
      acc_ff      <= acc_in;
      re_ff       <= re_in;
      im_ff       <= im_in;
      rsp_real_ff <= rsp_real_in;
      rsp_imag_ff <= rsp_imag_in;
      rsp_pad_ff  <= rsp_pad_in;
   end

   // Partial product phases only run inside the skip loop
   a_phase_in_skip: assert property (@(posedge clock) disable iff (reset)
      (ph_ff != PH_TEST) |-> (state_ff == ST_SKIP))
      else $error("multiply phase active outside skip loop");

   // Table index stays inside the jump table while count bits remain
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP && jump_ff != '0) |-> (k_ff < KW'(JUMP_BITS)))
      else $error("jump table index out of range");

   // A waiting result word is never overwritten
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp.ready) |=>
      (state_ff == ST_FIN && rsp_valid_ff))
      else $error("result word overwritten while stalled");

   // Padding words carry zero values
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pad_ff) |-> (rsp_real_ff == '0 && rsp_imag_ff == '0))
      else $error("padding word with nonzero value");

   // Real mode words have no imaginary part
   a_real_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !cfg.complex_mode) |-> (rsp_imag_ff == '0))
      else $error("imaginary part in real mode");

endmodule
`default_nettype wire

[hw/rtl/lcg_skip_ahead_tile_element_gen.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lcg_skip_ahead_tile_element_gen: random matrix element generator
// Configuration registers, range clamping and the generator core.
// ---------------------------------------------------------------------------
// One request word (tile coordinates and position in the tile) gives one
// response word. The element value comes from a 64-bit LCG jumped ahead from
// the seed by row + col * total_rows steps (twice that in complex mode). All
// arithmetic runs on one shared 32x32 multiplier, and each 64-bit LCG product
// takes three passes through it. The skip loop tests the jump count bit by
// bit and runs an LCG product for each set bit; complex mode adds one plain
// LCG step for the imaginary part. A padding element skips the loop and
// goes straight to the output stage. The request side is ready only while
// the sequencer is idle; a finished word waits in the output register
// without blocking the next request, and a second finished word holds the
// sequencer until the first one is taken. Registers must be written by the
// user only while the block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module lcg_skip_ahead_tile_element_gen (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [lsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lsa_pkg::CSR_DATA_W-1:0] csr_wdata,
   lsa_req_if.sink                        req_chan,
   lsa_rsp_if.source                      rsp_chan
);
   import lsa_pkg::*;

   logic [63:0]       seed_ff;
   logic [DIM_W-1:0]  total_rows_ff;
   logic [DIM_W-1:0]  total_cols_ff;
   logic [DIM_W-1:0]  local_rows_ff;
   logic [DIM_W-1:0]  local_cols_ff;
   logic [TILE_W-1:0] tile_size_ff;
   logic              cholesky_ff;
   logic              complex_ff;

   lsa_cfg_type       cfg;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= 64'd100;
         total_rows_ff <= DIM_W'(1);
         total_cols_ff <= DIM_W'(1);
         local_rows_ff <= '0;
         local_cols_ff <= '0;
         tile_size_ff  <= TILE_W'(1);
         cholesky_ff   <= 1'b0;
         complex_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (lsa_csr_type'(csr_index))
            CSR_SEED:       seed_ff       <= csr_wdata;
            CSR_TOTAL_ROWS: total_rows_ff <= csr_wdata[DIM_W-1:0];
            CSR_TOTAL_COLS: total_cols_ff <= csr_wdata[DIM_W-1:0];
            CSR_LOCAL_ROWS: local_rows_ff <= csr_wdata[DIM_W-1:0];
            CSR_LOCAL_COLS: local_cols_ff <= csr_wdata[DIM_W-1:0];
            CSR_TILE_SIZE:  tile_size_ff  <= csr_wdata[TILE_W-1:0];
            CSR_CHOLESKY:   cholesky_ff   <= csr_wdata[0];
            CSR_COMPLEX:    complex_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clamp sizes into their legal ranges
   always_comb begin
      cfg.seed          = seed_ff;
      cfg.total_rows    = (total_rows_ff == '0) ? DIM_W'(1) :
                          (total_rows_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : total_rows_ff;
      cfg.total_cols    = (total_cols_ff == '0) ? DIM_W'(1) :
                          (total_cols_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : total_cols_ff;
      cfg.local_rows    = (local_rows_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : local_rows_ff;
      cfg.local_cols    = (local_cols_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : local_cols_ff;
      cfg.tile_size     = (tile_size_ff == '0) ? TILE_W'(1) :
                          (tile_size_ff > TILE_W'(MAX_TILE)) ? TILE_W'(MAX_TILE) : tile_size_ff;
      cfg.cholesky_mode = cholesky_ff;
      cfg.complex_mode  = complex_ff;
   end

   lsa_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule
`default_nettype wire
